/* rtl/core/rsd_pkg.sv */
// Shared types and constants for the run-length sprite span decoder.
// Used by rsd_cfg, rsd_span and rle_sprite_span_decoder_core.
package rsd_pkg;

    typedef enum logic [3:0] {
        PH_HDR0    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_LEFT_LO = 4'd2,
        PH_LEFT_HI = 4'd3,
        PH_TOP_LO  = 4'd4,
        PH_TOP_HI  = 4'd5,
        PH_HDR6    = 4'd6,
        PH_HDR7    = 4'd7,
        PH_CODE_LO = 4'd8,
        PH_CODE_HI = 4'd9,
        PH_DX_LO   = 4'd10,
        PH_DX_HI   = 4'd11,
        PH_DY_LO   = 4'd12,
        PH_DY_HI   = 4'd13,
        PH_COLOR   = 4'd14,
        PH_SUB     = 4'd15
    } phase_t;

    localparam logic [1:0] ST_SPAN  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [2:0] REG_POS_X        = 3'd0;
    localparam logic [2:0] REG_POS_Y        = 3'd1;
    localparam logic [2:0] REG_BUF_WIDTH    = 3'd2;
    localparam logic [2:0] REG_BUF_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_COLOR_OFFSET = 3'd4;
    localparam logic [2:0] REG_CLIP_ENABLE  = 3'd5;
    localparam logic [2:0] REG_CLIP_X       = 3'd6;
    localparam logic [2:0] REG_CLIP_Y       = 3'd7;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [12:0]        buf_width;
        logic [12:0]        buf_height;
        logic [7:0]         color_offset;
        logic               clip_enable;
        logic [31:0]        clip_x_bounds;
        logic [31:0]        clip_y_bounds;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [15:0]        texels_done;
        logic [6:0]         count;
    } span_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] address;
        logic [6:0]  length;
    } span_res_t;

endpackage

/* rtl/core/rsd_cfg.sv */
// Configuration register bank of the sprite span decoder.
// Depends on rsd_pkg for register indexes and the cfg_t bundle.
module rsd_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output rsd_pkg::cfg_t      cfg
);

    rsd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x         <= '0;
            cfg_reg.pos_y         <= '0;
            cfg_reg.buf_width     <= 13'd320;
            cfg_reg.buf_height    <= 13'd200;
            cfg_reg.color_offset  <= '0;
            cfg_reg.clip_enable   <= 1'b0;
            cfg_reg.clip_x_bounds <= '0;
            cfg_reg.clip_y_bounds <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rsd_pkg::REG_POS_X:        cfg_reg.pos_x         <= cfg_data[15:0];
                rsd_pkg::REG_POS_Y:        cfg_reg.pos_y         <= cfg_data[15:0];
                rsd_pkg::REG_BUF_WIDTH:    cfg_reg.buf_width     <= cfg_data[12:0];
                rsd_pkg::REG_BUF_HEIGHT:   cfg_reg.buf_height    <= cfg_data[12:0];
                rsd_pkg::REG_COLOR_OFFSET: cfg_reg.color_offset  <= cfg_data[7:0];
                rsd_pkg::REG_CLIP_ENABLE:  cfg_reg.clip_enable   <= cfg_data[0];
                rsd_pkg::REG_CLIP_X:       cfg_reg.clip_x_bounds <= cfg_data;
                rsd_pkg::REG_CLIP_Y:       cfg_reg.clip_y_bounds <= cfg_data;
                default:                   cfg_reg.clip_enable   <= cfg_reg.clip_enable;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/rsd_span.sv */
// Span geometry: clip window, linear address and buffer bounds for one run.
// Depends on rsd_pkg; purely combinational, one row multiply per run.
module rsd_span #(
    parameter int MAX_BUF_DIM = 4096
) (
    input  rsd_pkg::cfg_t     cfg,
    input  rsd_pkg::span_req_t req,
    output rsd_pkg::span_res_t res
);

    logic [12:0]        w;
    logic [12:0]        h;
    logic [25:0]        wh;
    logic signed [17:0] ysum;
    logic signed [16:0] yscr;
    logic signed [31:0] row;
    logic signed [19:0] x0;
    logic signed [21:0] lo_raw;
    logic signed [21:0] hi_raw;
    logic signed [21:0] n_last;
    logic signed [21:0] lo_c;
    logic signed [21:0] hi_c;
    logic signed [21:0] cnt;
    logic               y_ok;
    logic               none;
    logic signed [33:0] base;
    logic signed [33:0] addr_lo;
    logic signed [34:0] room;
    logic signed [15:0] xmin;
    logic signed [15:0] xmax;
    logic signed [15:0] ymin;
    logic signed [15:0] ymax;

    assign w = (cfg.buf_width > 13'(MAX_BUF_DIM)) ? 13'(MAX_BUF_DIM) : cfg.buf_width;
    assign h = (cfg.buf_height > 13'(MAX_BUF_DIM)) ? 13'(MAX_BUF_DIM) : cfg.buf_height;
    assign wh = w * h;

    assign xmin = cfg.clip_x_bounds[15:0];
    assign xmax = cfg.clip_x_bounds[31:16];
    assign ymin = cfg.clip_y_bounds[15:0];
    assign ymax = cfg.clip_y_bounds[31:16];

    assign ysum = 18'(req.top) + 18'(cfg.pos_y) + 18'(req.dy);
    assign yscr = 17'(cfg.pos_y) + 17'(req.dy);
    assign row  = ysum * $signed({1'b0, w});
    assign x0   = 20'(cfg.pos_x) + 20'(req.dx) + $signed({4'b0, req.texels_done});

    assign y_ok   = (17'(ymin) <= yscr) && (yscr <= 17'(ymax));
    assign lo_raw = 22'(xmin) - 22'(x0);
    assign hi_raw = 22'(xmax) - 22'(x0);
    assign n_last = $signed({15'b0, req.count}) - 22'sd1;

    always_comb
    begin
        if (cfg.clip_enable)
        begin
            lo_c = (lo_raw < 0) ? 22'sd0 : lo_raw;
            hi_c = (hi_raw < n_last) ? hi_raw : n_last;
        end
        else
        begin
            lo_c = 22'sd0;
            hi_c = n_last;
        end
    end

    assign none    = (cfg.clip_enable && !y_ok) || (lo_c > hi_c);
    assign cnt     = hi_c - lo_c + 22'sd1;
    assign base    = 34'(req.left) + 34'(x0) + 34'(row);
    assign addr_lo = base + 34'(lo_c);
    assign room    = $signed({9'b0, wh}) - 35'(addr_lo);

    always_comb
    begin
        res.status  = rsd_pkg::ST_SPAN;
        res.address = '0;
        res.length  = '0;
        priority if (none)
        begin
            res.status = rsd_pkg::ST_SPAN;
        end
        else if (addr_lo < 0 || room <= 0)
        begin
            res.status = rsd_pkg::ST_ERROR;
        end
        else if (room < 35'(cnt))
        begin
            res.status  = rsd_pkg::ST_ERROR;
            res.address = addr_lo[23:0];
            res.length  = room[6:0];
        end
        else
        begin
            res.address = addr_lo[23:0];
            res.length  = cnt[6:0];
        end
    end

endmodule

/* rtl/core/rle_sprite_span_decoder_core.sv */
// Top level of the run-length sprite span decoder: byte parser and result register.
// Depends on rsd_pkg, rsd_cfg and rsd_span.
//
//  Port group | Direction | Handshake          | Content
//  input      | in        | in_valid/in_ready  | data_byte, shape_start
//  output     | out       | out_valid/out_ready| status, pixel_address, span_length,
//             |           |                    | pixel_color, bytes_consumed
//  config     | in        | cfg_wr_en          | cfg_index, cfg_data
//
// One byte per cycle unless out_ready stalls; a result shows in the next cycle.
// The critical path is the per-run row multiply plus the bounds compare.
// Reset clears the parser and loads register defaults.
// A byte is taken whenever the result register is empty or being drained.
module rle_sprite_span_decoder_core #(
    parameter int MAX_BUF_DIM = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        shape_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [23:0] pixel_address,
    output logic [6:0]  span_length,
    output logic [7:0]  pixel_color,
    output logic [15:0] bytes_consumed,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rsd_pkg::cfg_t      cfg;
    rsd_pkg::span_req_t req;
    rsd_pkg::span_res_t span;

    rsd_pkg::phase_t phase_reg, phase_next, ph_cur;
    logic [15:0] left_reg, left_next;
    logic [15:0] top_reg, top_next;
    logic [7:0]  hold_reg, hold_next, hold_cur;
    logic [15:0] dx_reg, dx_next;
    logic [15:0] dy_reg, dy_next;
    logic [14:0] total_reg, total_next;
    logic        comp_reg, comp_next;
    logic [15:0] td_reg, td_next, td_run;
    logic [6:0]  sub_reg, sub_next;
    logic [15:0] bc_reg, bc_next, bc_inc;
    logic        err_reg, err_next;

    logic        accept;
    logic        has_res;
    logic        use_span;
    logic [1:0]  res_status;
    logic [23:0] res_addr;
    logic [6:0]  res_len;
    logic [7:0]  res_color;
    logic [15:0] res_bytes;
    logic [15:0] code;
    logic        skip;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [23:0] addr_reg;
    logic [6:0]  len_reg;
    logic [7:0]  color_reg;
    logic [15:0] bytes_reg;

    rsd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign req.left        = left_reg;
    assign req.top         = top_reg;
    assign req.dx          = dx_reg;
    assign req.dy          = dy_reg;
    assign req.texels_done = td_reg;
    assign req.count       = (phase_reg == rsd_pkg::PH_COLOR) ? 7'd1 : sub_reg;

    rsd_span #(
        .MAX_BUF_DIM (MAX_BUF_DIM)
    ) u_span (
        .cfg (cfg),
        .req (req),
        .res (span)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign skip     = !shape_start && err_reg;
    assign ph_cur   = shape_start ? rsd_pkg::PH_HDR0 : phase_reg;
    assign hold_cur = shape_start ? 8'd0 : hold_reg;
    assign code     = {data_byte, hold_cur};
    assign bc_inc   = (ph_cur >= rsd_pkg::PH_CODE_LO && bc_reg != 16'hFFFF)
                      ? bc_reg + 16'd1 : bc_reg;
    assign td_run   = td_reg + ((phase_reg == rsd_pkg::PH_COLOR) ? 16'd1 : {9'b0, sub_reg});

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        top_next   = top_reg;
        hold_next  = hold_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        total_next = total_reg;
        comp_next  = comp_reg;
        td_next    = td_reg;
        sub_next   = sub_reg;
        bc_next    = bc_reg;
        err_next   = err_reg;
        if (shape_start)
        begin
            left_next  = '0;
            top_next   = '0;
            dx_next    = '0;
            dy_next    = '0;
            total_next = '0;
            comp_next  = 1'b0;
            td_next    = '0;
            sub_next   = '0;
            err_next   = 1'b0;
        end
        if (!skip)
        begin
            bc_next   = shape_start ? 16'd0 : bc_inc;
            hold_next = hold_cur;
            unique case (ph_cur)
                rsd_pkg::PH_LEFT_LO, rsd_pkg::PH_TOP_LO, rsd_pkg::PH_CODE_LO,
                rsd_pkg::PH_DX_LO, rsd_pkg::PH_DY_LO:
                begin
                    hold_next  = data_byte;
                    phase_next = rsd_pkg::phase_t'(ph_cur + 4'd1);
                end
                rsd_pkg::PH_LEFT_HI:
                begin
                    left_next  = code;
                    phase_next = rsd_pkg::PH_TOP_LO;
                end
                rsd_pkg::PH_TOP_HI:
                begin
                    top_next   = code;
                    phase_next = rsd_pkg::PH_HDR6;
                end
                rsd_pkg::PH_CODE_HI:
                begin
                    hold_next = '0;
                    if (code == 16'd0)
                    begin
                        phase_next = rsd_pkg::PH_HDR0;
                        bc_next    = '0;
                    end
                    else
                    begin
                        comp_next  = code[0];
                        total_next = code[15:1];
                        phase_next = rsd_pkg::PH_DX_LO;
                    end
                end
                rsd_pkg::PH_DX_HI:
                begin
                    dx_next    = code;
                    phase_next = rsd_pkg::PH_DY_LO;
                end
                rsd_pkg::PH_DY_HI:
                begin
                    dy_next   = code;
                    hold_next = '0;
                    td_next   = '0;
                    sub_next  = '0;
                    if (total_reg == 15'd0)
                        phase_next = rsd_pkg::PH_CODE_LO;
                    else
                        phase_next = comp_reg ? rsd_pkg::PH_SUB : rsd_pkg::PH_COLOR;
                end
                rsd_pkg::PH_COLOR:
                begin
                    td_next = td_run;
                    if (span.status == rsd_pkg::ST_ERROR)
                        err_next = 1'b1;
                    if (comp_reg)
                    begin
                        sub_next = sub_reg - 7'd1;
                        if (sub_reg == 7'd1)
                            phase_next = (td_run < {1'b0, total_reg})
                                         ? rsd_pkg::PH_SUB : rsd_pkg::PH_CODE_LO;
                    end
                    else if (td_run >= {1'b0, total_reg})
                    begin
                        phase_next = rsd_pkg::PH_CODE_LO;
                    end
                end
                rsd_pkg::PH_SUB:
                begin
                    if (hold_cur != 8'd0)
                    begin
                        td_next   = td_run;
                        sub_next  = '0;
                        hold_next = '0;
                        if (span.status == rsd_pkg::ST_ERROR)
                            err_next = 1'b1;
                        phase_next = (comp_reg && td_run < {1'b0, total_reg})
                                     ? rsd_pkg::PH_SUB : rsd_pkg::PH_CODE_LO;
                    end
                    else
                    begin
                        sub_next = data_byte[7:1];
                        if (data_byte[0])
                            hold_next = 8'd1;
                        else if (data_byte[7:1] != 7'd0)
                            phase_next = rsd_pkg::PH_COLOR;
                        else
                            phase_next = (comp_reg && td_reg < {1'b0, total_reg})
                                         ? rsd_pkg::PH_SUB : rsd_pkg::PH_CODE_LO;
                    end
                end
                default:
                begin
                    phase_next = rsd_pkg::phase_t'(ph_cur + 4'd1);
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        has_res   = 1'b0;
        use_span  = 1'b0;
        res_bytes = '0;
        if (!skip)
        begin
            unique case (ph_cur)
                rsd_pkg::PH_CODE_HI:
                begin
                    has_res   = (code == 16'd0);
                    res_bytes = bc_inc;
                end
                rsd_pkg::PH_COLOR:
                begin
                    has_res  = 1'b1;
                    use_span = 1'b1;
                end
                rsd_pkg::PH_SUB:
                begin
                    has_res  = (hold_cur != 8'd0);
                    use_span = 1'b1;
                end
                default:
                begin
                    has_res = 1'b0;
                end
            endcase
        end
        res_status = use_span ? span.status : rsd_pkg::ST_DONE;
        res_addr   = use_span ? span.address : 24'd0;
        res_len    = use_span ? span.length : 7'd0;
        res_color  = use_span ? data_byte + cfg.color_offset : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rsd_pkg::PH_HDR0;
            left_reg  <= '0;
            top_reg   <= '0;
            hold_reg  <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            total_reg <= '0;
            comp_reg  <= 1'b0;
            td_reg    <= '0;
            sub_reg   <= '0;
            bc_reg    <= '0;
            err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            top_reg   <= top_next;
            hold_reg  <= hold_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            total_reg <= total_next;
            comp_reg  <= comp_next;
            td_reg    <= td_next;
            sub_reg   <= sub_next;
            bc_reg    <= bc_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= has_res;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_res)
        begin
            status_reg <= res_status;
            addr_reg   <= res_addr;
            len_reg    <= res_len;
            color_reg  <= res_color;
            bytes_reg  <= res_bytes;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign pixel_address  = addr_reg;
    assign span_length    = len_reg;
    assign pixel_color    = color_reg;
    assign bytes_consumed = bytes_reg;

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == rsd_pkg::ST_DONE |-> addr_reg == 24'd0 && len_reg == 7'd0)
        else $error("done transaction carries span data");

    a_err_latched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == rsd_pkg::ST_ERROR |-> err_reg)
        else $error("bounds error shown without parser lock");

    a_empty_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == rsd_pkg::ST_SPAN && len_reg == 7'd0 |-> addr_reg == 24'd0)
        else $error("empty span with nonzero address");

    a_locked_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && err_reg && !shape_start |=> !out_valid_reg)
        else $error("result produced while locked after error");

endmodule

/* verif/rsd_span_checker.sv */
// Span checker for the run-length sprite span decoder: watches the byte, result and
// register ports, predicts every span/done/error result and compares them in order.
// Depends on rsd_pkg for phase, status and register codes.
`timescale 1ns / 100ps

module rsd_span_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        shape_start,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [23:0] pixel_address,
    input  logic [6:0]  span_length,
    input  logic [7:0]  pixel_color,
    input  logic [15:0] bytes_consumed,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          n_span,
    output int          n_done,
    output int          n_err
);

    typedef struct packed {
        logic [1:0]  st;
        logic [23:0] addr;
        logic [6:0]  len;
        logic [7:0]  color;
        logic [15:0] bytes;
    } span_rec_t;

    span_rec_t expected_spans[$];

    logic [15:0] c_pos_x, c_pos_y;
    logic [12:0] c_width, c_height;
    logic [7:0]  c_color_off;
    logic        c_clip_en;
    logic [31:0] c_clip_x, c_clip_y;

    rsd_pkg::phase_t phase;
    logic [15:0] left_ofs, top_ofs;
    logic [7:0]  low_hold;
    logic [15:0] f_dx, f_dy;
    logic [14:0] f_total;
    logic        f_comp;
    logic [15:0] t_done;
    logic [6:0]  sub_rem;
    logic [15:0] b_count;
    logic        err_hold;

    function automatic void clear_parse();
        phase = rsd_pkg::PH_HDR0;
        left_ofs = '0; top_ofs = '0; low_hold = '0;
        f_dx = '0; f_dy = '0; f_total = '0; f_comp = 1'b0;
        t_done = '0; sub_rem = '0; b_count = '0; err_hold = 1'b0;
    endfunction

    function automatic span_rec_t emit_run(int n, logic [7:0] color);
        span_rec_t r;
        longint w, h, px, py, y, xmin, xmax, ymin, ymax, row, x, addr, first;
        int len;
        logic [1:0] st;
        w = (c_width > 13'd4096) ? 4096 : longint'(c_width);
        h = (c_height > 13'd4096) ? 4096 : longint'(c_height);
        px = longint'($signed(c_pos_x));
        py = longint'($signed(c_pos_y));
        y = longint'($signed(f_dy));
        xmin = longint'($signed(c_clip_x[15:0]));
        xmax = longint'($signed(c_clip_x[31:16]));
        ymin = longint'($signed(c_clip_y[15:0]));
        ymax = longint'($signed(c_clip_y[31:16]));
        row = (longint'($signed(top_ofs)) + py + y) * w;
        len = 0;
        first = 0;
        st = rsd_pkg::ST_SPAN;
        for (int i = 0; i < n; i++) begin
            x = longint'($signed(f_dx)) + longint'(t_done) + i;
            if (c_clip_en && (px + x < xmin || px + x > xmax || py + y < ymin || py + y > ymax))
                continue;
            addr = longint'($signed(left_ofs)) + px + x + row;
            if (addr < 0 || addr >= w * h) begin
                st = rsd_pkg::ST_ERROR;
                err_hold = 1'b1;
                break;
            end
            if (len == 0)
                first = addr;
            len++;
        end
        r.st = st;
        r.addr = first[23:0];
        r.len = len[6:0];
        r.color = color + c_color_off;
        r.bytes = '0;
        return r;
    endfunction

    function automatic void after_run();
        phase = (f_comp && t_done < {1'b0, f_total}) ? rsd_pkg::PH_SUB : rsd_pkg::PH_CODE_LO;
    endfunction

    function automatic bit decode_byte(logic [7:0] b, logic s, output span_rec_t r);
        bit has;
        logic [15:0] code;
        has = 1'b0;
        r = '0;
        if (s)
            clear_parse();
        else if (err_hold)
            return 1'b0;
        if (phase >= rsd_pkg::PH_CODE_LO && b_count != 16'hFFFF)
            b_count++;
        case (phase)
            rsd_pkg::PH_LEFT_LO, rsd_pkg::PH_TOP_LO, rsd_pkg::PH_CODE_LO,
            rsd_pkg::PH_DX_LO, rsd_pkg::PH_DY_LO: begin
                low_hold = b;
                phase = rsd_pkg::phase_t'(phase + 1);
            end
            rsd_pkg::PH_LEFT_HI: begin
                left_ofs = {b, low_hold};
                phase = rsd_pkg::phase_t'(phase + 1);
            end
            rsd_pkg::PH_TOP_HI: begin
                top_ofs = {b, low_hold};
                phase = rsd_pkg::phase_t'(phase + 1);
            end
            rsd_pkg::PH_CODE_HI: begin
                code = {b, low_hold};
                if (code == 16'd0) begin
                    r.st = rsd_pkg::ST_DONE;
                    r.bytes = b_count;
                    has = 1'b1;
                    phase = rsd_pkg::PH_HDR0;
                    b_count = '0;
                end else begin
                    f_comp = code[0];
                    f_total = code[15:1];
                    phase = rsd_pkg::PH_DX_LO;
                end
                low_hold = '0;
            end
            rsd_pkg::PH_DX_HI: begin
                f_dx = {b, low_hold};
                phase = rsd_pkg::PH_DY_LO;
            end
            rsd_pkg::PH_DY_HI: begin
                f_dy = {b, low_hold};
                low_hold = '0;
                t_done = '0;
                sub_rem = '0;
                if (f_total == 0)
                    phase = rsd_pkg::PH_CODE_LO;
                else
                    phase = f_comp ? rsd_pkg::PH_SUB : rsd_pkg::PH_COLOR;
            end
            rsd_pkg::PH_COLOR: begin
                r = emit_run(1, b);
                has = 1'b1;
                t_done = t_done + 16'd1;
                if (f_comp) begin
                    sub_rem = sub_rem - 7'd1;
                    if (sub_rem == 0)
                        after_run();
                end else if (t_done >= {1'b0, f_total}) begin
                    phase = rsd_pkg::PH_CODE_LO;
                end
            end
            rsd_pkg::PH_SUB: begin
                if (low_hold != 0) begin
                    r = emit_run(sub_rem, b);
                    has = 1'b1;
                    t_done = t_done + {9'd0, sub_rem};
                    sub_rem = '0;
                    low_hold = '0;
                    after_run();
                end else begin
                    sub_rem = b[7:1];
                    if (b[0])
                        low_hold = 8'd1;
                    else if (sub_rem != 0)
                        phase = rsd_pkg::PH_COLOR;
                    else
                        after_run();
                end
            end
            default: phase = rsd_pkg::phase_t'(phase + 1);
        endcase
        return has;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        span_rec_t r, e;
        if (!rst_n) begin
            c_pos_x = '0; c_pos_y = '0; c_width = 13'd320; c_height = 13'd200;
            c_color_off = '0; c_clip_en = 1'b0; c_clip_x = '0; c_clip_y = '0;
            clear_parse();
            expected_spans.delete();
            fail_count = 0; n_span = 0; n_done = 0; n_err = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    rsd_pkg::REG_POS_X:        c_pos_x = cfg_data[15:0];
                    rsd_pkg::REG_POS_Y:        c_pos_y = cfg_data[15:0];
                    rsd_pkg::REG_BUF_WIDTH:    c_width = cfg_data[12:0];
                    rsd_pkg::REG_BUF_HEIGHT:   c_height = cfg_data[12:0];
                    rsd_pkg::REG_COLOR_OFFSET: c_color_off = cfg_data[7:0];
                    rsd_pkg::REG_CLIP_ENABLE:  c_clip_en = cfg_data[0];
                    rsd_pkg::REG_CLIP_X:       c_clip_x = cfg_data;
                    rsd_pkg::REG_CLIP_Y:       c_clip_y = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                if (decode_byte(data_byte, shape_start, r))
                    expected_spans.push_back(r);
            end
            if (out_valid && out_ready) begin
                r = '{status, pixel_address, span_length, pixel_color, bytes_consumed};
                if (expected_spans.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result st=%0d addr=%0h len=%0d col=%0h bytes=%0d",
                                 r.st, r.addr, r.len, r.color, r.bytes);
                end else begin
                    e = expected_spans.pop_front();
                    case (e.st)
                        rsd_pkg::ST_DONE:  n_done++;
                        rsd_pkg::ST_ERROR: n_err++;
                        default:           n_span++;
                    endcase
                    if (r !== e) begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch exp st=%0d addr=%0h len=%0d col=%0h bytes=%0d",
                                     e.st, e.addr, e.len, e.color, e.bytes);
                            $display("         got st=%0d addr=%0h len=%0d col=%0h bytes=%0d",
                                     r.st, r.addr, r.len, r.color, r.bytes);
                        end
                    end
                end
            end
        end
        pending = expected_spans.size();
    end

endmodule

/* verif/tb.sv */
// Testbench top for rle_sprite_span_decoder_core: builds sprite byte streams and
// register settings, paces both handshakes and reports the verdict.
// Depends on rsd_pkg, the core and rsd_span_checker.
`timescale 1ns / 100ps

module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        shape_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [23:0] pixel_address;
    logic [6:0]  span_length;
    logic [7:0]  pixel_color;
    logic [15:0] bytes_consumed;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int fail_count, pending, n_span, n_done, n_err;
    int bytes_sent = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rle_sprite_span_decoder_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .shape_start(shape_start),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .pixel_address(pixel_address), .span_length(span_length),
        .pixel_color(pixel_color), .bytes_consumed(bytes_consumed),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rsd_span_checker chk (.*);

    initial begin
        #4ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        int cyc, hold_left;
        cyc = 0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            cyc++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case ((cyc / 64) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 1) != 0);
                    default: out_ready <= cyc[0];
                endcase
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        shape_start <= s;
        #1;
        while (!in_ready) begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_word(logic [15:0] w);
        send_byte(w[7:0], 1'b0);
        send_byte(w[15:8], 1'b0);
    endtask

    task automatic send_header(logic s, logic [15:0] left, logic [15:0] top);
        send_byte(8'($urandom), s);
        send_byte(8'($urandom), 1'b0);
        send_word(left);
        send_word(top);
        send_word(16'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // kind: 0 well-formed, 1 far offsets, 2 cut short
    task automatic send_shape(logic s, int kind);
        int nfrag, total, done, cnt, guard, rem;
        logic comp, rpt;
        logic [15:0] dx, dy;
        if (kind == 1)
            send_header(s, 16'($urandom), 16'($urandom));
        else
            send_header(s, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
        nfrag = $urandom_range(0, 4);
        for (int f = 0; f < nfrag; f++) begin
            if (kind == 2 && $urandom_range(0, 2) == 0)
                return;
            total = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
            comp = (total == 0) ? 1'b1 : ($urandom_range(0, 1) != 0);
            dx = (kind == 1 || $urandom_range(0, 15) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 80) - 20);
            dy = (kind == 1 || $urandom_range(0, 15) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 60) - 10);
            send_word({total[14:0], comp});
            send_word(dx);
            send_word(dy);
            if (total == 0)
                continue;
            if (!comp) begin
                for (int t = 0; t < total; t++)
                    send_byte(8'($urandom), 1'b0);
            end else begin
                done = 0;
                guard = 0;
                while (done < total) begin
                    rem = total - done;
                    if (guard > 12)
                        cnt = rem + $urandom_range(0, 3);
                    else
                        cnt = $urandom_range(0, (rem + 2 > 127) ? 127 : rem + 2);
                    if (cnt > 127)
                        cnt = 127;
                    rpt = ($urandom_range(0, 1) != 0);
                    send_byte({cnt[6:0], rpt}, 1'b0);
                    if (rpt)
                        send_byte(8'($urandom), 1'b0);
                    else
                        for (int k = 0; k < cnt; k++)
                            send_byte(8'($urandom), 1'b0);
                    done += cnt;
                    guard++;
                end
            end
        end
        send_word(16'd0);
    endtask

    task automatic set_phase(int p);
        logic [15:0] lo, hi;
        case (p % 6)
            0: begin
                cfg_write(rsd_pkg::REG_POS_X, $urandom_range(0, 60));
                cfg_write(rsd_pkg::REG_POS_Y, $urandom_range(0, 60));
                cfg_write(rsd_pkg::REG_BUF_WIDTH, 320);
                cfg_write(rsd_pkg::REG_BUF_HEIGHT, 200);
                cfg_write(rsd_pkg::REG_COLOR_OFFSET, $urandom_range(0, 255));
                cfg_write(rsd_pkg::REG_CLIP_ENABLE, 0);
            end
            1: begin
                cfg_write(rsd_pkg::REG_POS_X, (p % 12 == 1) ? 32'h8000 : 32'h7FFF);
                cfg_write(rsd_pkg::REG_POS_Y, (p % 12 == 1) ? 32'h7FFF : 32'h8000);
                cfg_write(rsd_pkg::REG_BUF_WIDTH, 4096);
                cfg_write(rsd_pkg::REG_BUF_HEIGHT, 4096);
            end
            2: begin
                cfg_write(rsd_pkg::REG_POS_X, 0);
                cfg_write(rsd_pkg::REG_POS_Y, 0);
                cfg_write(rsd_pkg::REG_BUF_WIDTH, 1);
                cfg_write(rsd_pkg::REG_BUF_HEIGHT, 1);
            end
            3: begin
                cfg_write(rsd_pkg::REG_BUF_WIDTH, (p % 12 == 3) ? 0 : 8191);
                cfg_write(rsd_pkg::REG_BUF_HEIGHT, (p % 12 == 3) ? 8191 : 0);
            end
            4: begin
                cfg_write(rsd_pkg::REG_BUF_WIDTH, $urandom_range(16, 512));
                cfg_write(rsd_pkg::REG_BUF_HEIGHT, $urandom_range(16, 512));
                lo = 16'($urandom_range(0, 30));
                hi = lo + 16'($urandom_range(0, 50));
                cfg_write(rsd_pkg::REG_CLIP_X, {hi, lo});
                lo = 16'($urandom_range(0, 30));
                hi = lo + 16'($urandom_range(0, 50));
                cfg_write(rsd_pkg::REG_CLIP_Y, {hi, lo});
                cfg_write(rsd_pkg::REG_CLIP_ENABLE, 1);
            end
            default: begin
                cfg_write(rsd_pkg::REG_CLIP_X, (p % 12 == 5) ? 32'h0000_0010 : $urandom);
                cfg_write(rsd_pkg::REG_CLIP_Y, (p % 12 == 5) ? 32'h7FFF_8000 : $urandom);
                cfg_write(rsd_pkg::REG_COLOR_OFFSET, 255);
            end
        endcase
    endtask

    initial begin
        int fails, sel, target, nnoise;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // raw pair at color extremes, compressed runs incl. zero counts, empty fragment
        send_header(1'b1, 16'd0, 16'd0);
        send_word(16'h0004); send_word(16'd0); send_word(16'd0);
        send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
        send_word(16'h000B); send_word(16'hFFFE); send_word(16'd3);
        send_byte(8'h07, 1'b0); send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0); send_byte(8'h55, 1'b0);
        send_byte(8'h09, 1'b0); send_byte(8'h12, 1'b0);
        send_word(16'h0001); send_word(16'd0); send_word(16'd0);
        send_word(16'd0);
        // next shape without a start mark, falls off the top of the buffer
        send_header(1'b0, 16'd0, 16'd0);
        send_word(16'h0002); send_word(16'd0); send_word(16'hFF00);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        wait_idle();

        for (int p = 0; p < 12; p++) begin
            set_phase(p);
            if (p == 7)
                cfg_write(rsd_pkg::REG_CLIP_ENABLE, 0);
            if (p == 1)
                hold_req = 1'b1;
            target = bytes_sent + 100;
            while (bytes_sent < target) begin
                sel = $urandom_range(0, 99);
                if (sel < 80)
                    send_shape($urandom_range(0, 6) != 0, 0);
                else if (sel < 88)
                    send_shape(1'b1, 1);
                else if (sel < 94)
                    send_shape(1'b1, 2);
                else begin
                    nnoise = $urandom_range(1, 10);
                    repeat (nnoise) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end
            end
            wait_idle();
        end

        wait_idle();
        fails = fail_count + pending;
        $display("sent %0d bytes over 12 register settings", bytes_sent);
        $display("checked %0d spans, %0d shape ends, %0d bounds errors", n_span, n_done, n_err);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rsd_pkg.sv
rtl/core/rsd_cfg.sv
rtl/core/rsd_span.sv
rtl/core/rle_sprite_span_decoder_core.sv
verif/rsd_span_checker.sv
verif/tb.sv
